// ----- src/vks_pkg.sv -----
// ----------------------------------------------------------------------------
// vks_pkg: shared types and constants for the kinematic step block
// Holds the angle constants, the configuration register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package vks_pkg;

    localparam int TWO_PI_Q12 = 25736;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic [1:0] REG_INV_WHEELBASE = 2'd0;
    localparam logic [1:0] REG_MIN_STEER     = 2'd1;
    localparam logic [1:0] REG_MAX_STEER     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE_S,
        ST_PHASE_H,
        ST_LOOKUP,
        ST_DV,
        ST_DH1,
        ST_DH2,
        ST_DS,
        ST_CC,
        ST_DX,
        ST_DY,
        ST_UPDATE,
        ST_OUT
    } state_t;

endpackage

// ----- src/vks_mul.sv -----
// ----------------------------------------------------------------------------
// vks_mul: shared signed multiplier with registered product
// One 33 x 33 signed product per cycle, shared by the multiply steps of the sequencer.
// ----------------------------------------------------------------------------
module vks_mul (
    input  logic               aclk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] prod
);

    logic signed [65:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- src/vehicle_kinematic_step.sv -----
// ----------------------------------------------------------------------------
// vehicle_kinematic_step: one kinematic bicycle model step per input beat
// Keeps the vehicle pose and advances it by one time step per input beat.
// ----------------------------------------------------------------------------
// A result beat is made valid after the whole update has run: its steps
// run one after another through a single shared multiplier with a
// registered product, and the block takes no new beat until its result
// has been taken.
// Angle phases come from multiplying by a constant reciprocal; sin and cos
// come from a quarter-wave constant table.
module vehicle_kinematic_step #(
    parameter int TRIG_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // time_step [15:0], velocity [31:16], steer_rate [47:32]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pos_x [31:0], pos_y [63:32], steer_angle [77:64], heading [92:78],
    // elapsed [124:93], zero fill [127:125]
    output logic [127:0] m_tdata
);

    localparam int QBITS = $clog2(TRIG_TABLE_DEPTH);
    localparam int FULL = 4 * TRIG_TABLE_DEPTH;
    localparam int PBITS = QBITS + 2;
    // Reciprocal of 2pi in Q4.12 scaled by 2^40, for phase = round(a*FULL/2pi).
    localparam longint RECIP = ((64'sd1 <<< 40) + vks_pkg::TWO_PI_Q12 - 1)
                               / vks_pkg::TWO_PI_Q12;

    // Quarter-wave table: sin(i*pi/(2*depth)) in unsigned Q1.14, from a Taylor series in Q30.
    logic [14:0] sine_rom [TRIG_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= TRIG_TABLE_DEPTH; gi++) begin : g_sine
        localparam longint X  = (vks_pkg::HALF_PI_Q30 * longint'(gi)) / TRIG_TABLE_DEPTH;
        localparam longint X2 = (X * X) >>> 30;
        localparam longint T1 = ((X * X2) >>> 30) / 6;
        localparam longint T2 = ((T1 * X2) >>> 30) / 20;
        localparam longint T3 = ((T2 * X2) >>> 30) / 42;
        localparam longint T4 = ((T3 * X2) >>> 30) / 72;
        localparam longint T5 = ((T4 * X2) >>> 30) / 110;
        localparam longint T6 = ((T5 * X2) >>> 30) / 156;
        localparam longint T7 = ((T6 * X2) >>> 30) / 210;
        localparam longint T8 = ((T7 * X2) >>> 30) / 272;
        localparam longint T9 = ((T8 * X2) >>> 30) / 342;
        localparam longint SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9;
        localparam longint POS = (SUM < 0) ? 64'sd0 : SUM;
        assign sine_rom[gi] = 15'((POS + 32768) >>> 16);
    end

    function automatic logic signed [15:0] sine_of(input logic [PBITS-1:0] n);
        logic [QBITS-1:0] idx;
        logic [14:0] v;
        idx = n[QBITS-1:0];
        if (n[QBITS] == 1'b0) v = sine_rom[{1'b0, idx}];
        else v = sine_rom[(QBITS+1)'(TRIG_TABLE_DEPTH) - {1'b0, idx}];
        return n[QBITS+1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    vks_pkg::state_t state_reg, state_next;

    logic [15:0]        inv_wb_reg;
    logic signed [13:0] min_st_reg;
    logic [12:0]        max_st_reg;

    logic signed [31:0] x_reg, y_reg;
    logic signed [13:0] steer_reg;
    logic [14:0]        head_reg;
    logic [31:0]        elapsed_reg;

    logic [15:0]        dt_reg;
    logic signed [15:0] vel_reg, rate_reg;
    logic [PBITS-1:0]   sp_reg, hp_reg;
    logic signed [15:0] ssin_reg, scos_reg, hsin_reg, hcos_reg;
    logic signed [32:0] dv_reg;
    logic signed [32:0] t1_reg;
    logic signed [15:0] dh_reg;
    logic signed [13:0] ns_reg;
    logic signed [31:0] dx_reg;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;

    vks_mul u_mul (.aclk(aclk), .op_a(op_a), .op_b(op_b), .prod(prod));

    // Phase from product p = (a + 4pi) * RECIP: value*FULL/2pi in 2^-40 units.
    function automatic logic [PBITS-1:0] phase_of(input logic signed [65:0] p);
        logic [65:0] q;
        q = 66'(p) * 66'(FULL) + (66'd1 <<< 39);
        return PBITS'(q >> 40);
    endfunction

    function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int k);
        return (v + (66'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7fffffff;
        if (v < -34'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vks_pkg::ST_IDLE:    if (s_tvalid) state_next = vks_pkg::ST_PHASE_S;
            vks_pkg::ST_PHASE_S: state_next = vks_pkg::ST_PHASE_H;
            vks_pkg::ST_PHASE_H: state_next = vks_pkg::ST_LOOKUP;
            vks_pkg::ST_LOOKUP:  state_next = vks_pkg::ST_DV;
            vks_pkg::ST_DV:      state_next = vks_pkg::ST_DH1;
            vks_pkg::ST_DH1:     state_next = vks_pkg::ST_DH2;
            vks_pkg::ST_DH2:     state_next = vks_pkg::ST_DS;
            vks_pkg::ST_DS:      state_next = vks_pkg::ST_CC;
            vks_pkg::ST_CC:      state_next = vks_pkg::ST_DX;
            vks_pkg::ST_DX:      state_next = vks_pkg::ST_DY;
            vks_pkg::ST_DY:      state_next = vks_pkg::ST_UPDATE;
            vks_pkg::ST_UPDATE:  state_next = vks_pkg::ST_OUT;
            vks_pkg::ST_OUT:     if (m_tready) state_next = vks_pkg::ST_IDLE;
            default:             state_next = vks_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operands; the product is registered and appears in the next cycle.
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            vks_pkg::ST_IDLE: begin
                op_a = 33'(signed'(steer_reg)) + 33'(2 * vks_pkg::TWO_PI_Q12);
                op_b = 33'(RECIP);
            end
            vks_pkg::ST_PHASE_S: begin
                op_a = 33'({1'b0, head_reg}) + 33'(2 * vks_pkg::TWO_PI_Q12);
                op_b = 33'(RECIP);
            end
            vks_pkg::ST_LOOKUP: begin
                op_a = 33'({1'b0, dt_reg});
                op_b = 33'(vel_reg);
            end
            vks_pkg::ST_DV: begin
                op_a = 33'({1'b0, inv_wb_reg});
                op_b = 33'(ssin_reg);
            end
            // The product of the inverse wheelbase and the steering sine is
            // fed straight back from the multiplier output.
            vks_pkg::ST_DH1: begin
                op_a = dv_reg;
                op_b = prod[32:0];
            end
            vks_pkg::ST_DH2: begin
                op_a = 33'({1'b0, dt_reg});
                op_b = 33'(rate_reg);
            end
            vks_pkg::ST_DS: begin
                op_a = 33'(scos_reg);
                op_b = 33'(hcos_reg);
            end
            vks_pkg::ST_CC: begin
                op_a = 33'(scos_reg);
                op_b = 33'(hsin_reg);
            end
            vks_pkg::ST_DX: begin
                op_a = dv_reg;
                op_b = t1_reg;
            end
            vks_pkg::ST_DY: begin
                op_a = dv_reg;
                op_b = t1_reg;
            end
            default: ;
        endcase
    end

    logic signed [65:0] dh_full, ds_full, nh_s;
    logic signed [17:0] ns_w;
    always_comb begin
        dh_full = rnd(prod, 34);
        if (dh_full > 66'sd25736) dh_full = 66'sd25736;
        if (dh_full < -66'sd25736) dh_full = -66'sd25736;
        ds_full = rnd(prod, 16);
        ns_w = 18'(signed'(steer_reg)) + 18'(ds_full);
        if (ns_w < 18'(min_st_reg)) ns_w = 18'(min_st_reg);
        if (ns_w > $signed({5'b00000, max_st_reg})) ns_w = $signed({5'b00000, max_st_reg});
        nh_s = 66'({1'b0, head_reg}) + 66'(dh_reg);
        if (nh_s < 0) nh_s = nh_s + 66'(vks_pkg::TWO_PI_Q12);
        if (nh_s > 66'sd25736) nh_s = nh_s - 66'(vks_pkg::TWO_PI_Q12);
    end

    // The y delta is taken straight from the product in the update cycle.
    logic signed [65:0] dy_full;
    logic signed [33:0] sx, sy;
    assign dy_full = rnd(prod, 36);
    assign sx = 34'(x_reg) + 34'(dx_reg);
    assign sy = 34'(y_reg) + 34'(dy_full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vks_pkg::ST_IDLE;
            inv_wb_reg  <= 16'd102;
            min_st_reg  <= -14'sd2145;
            max_st_reg  <= 13'd2145;
            x_reg       <= '0;
            y_reg       <= '0;
            steer_reg   <= '0;
            head_reg    <= '0;
            elapsed_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    vks_pkg::REG_INV_WHEELBASE: inv_wb_reg <= cfg_wdata;
                    vks_pkg::REG_MIN_STEER:     min_st_reg <= cfg_wdata[13:0];
                    vks_pkg::REG_MAX_STEER:     max_st_reg <= cfg_wdata[12:0];
                    default: ;
                endcase
            end
            if (state_reg == vks_pkg::ST_UPDATE) begin
                x_reg       <= sat(sx);
                y_reg       <= sat(sy);
                steer_reg   <= ns_reg;
                head_reg    <= nh_s[14:0];
                elapsed_reg <= elapsed_reg + 32'(dt_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            vks_pkg::ST_IDLE: begin
                dt_reg   <= s_tdata[15:0];
                vel_reg  <= s_tdata[31:16];
                rate_reg <= s_tdata[47:32];
            end
            vks_pkg::ST_PHASE_S: sp_reg <= phase_of(prod);
            vks_pkg::ST_PHASE_H: hp_reg <= phase_of(prod);
            vks_pkg::ST_LOOKUP: begin
                ssin_reg <= sine_of(sp_reg);
                scos_reg <= sine_of(sp_reg + PBITS'(TRIG_TABLE_DEPTH));
                hsin_reg <= sine_of(hp_reg);
                hcos_reg <= sine_of(hp_reg + PBITS'(TRIG_TABLE_DEPTH));
            end
            vks_pkg::ST_DV:  dv_reg <= prod[32:0];
            vks_pkg::ST_DH2: dh_reg <= dh_full[15:0];
            vks_pkg::ST_DS:  ns_reg <= ns_w[13:0];
            vks_pkg::ST_CC:  t1_reg <= prod[32:0];
            vks_pkg::ST_DX:  t1_reg <= prod[32:0];
            vks_pkg::ST_DY:  dx_reg <= 32'(rnd(prod, 36));
            default: ;
        endcase
    end

    assign s_tready = (state_reg == vks_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == vks_pkg::ST_OUT);
    assign m_tdata  = {3'b000, elapsed_reg, head_reg, steer_reg, y_reg, x_reg};

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vehicle_kinematic_step
// Drives time steps into the block, predicts each new pose with a bit-true
// model of the fixed-point update, and checks every result beat against it
// under several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [13:0] steer_angle;
    logic [14:0] heading;
    logic [31:0] elapsed;
} pose_t;

class pose_scoreboard;
    localparam int DEPTH = 256;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint TWO_PI = 25736;

    longint sine_tab[DEPTH + 1];
    logic [15:0] inv_wheelbase;
    longint min_steer;
    longint max_steer;
    longint x_pos;
    longint y_pos;
    longint steer;
    longint head;
    logic [31:0] elapsed;
    pose_t pending[$];
    int errors;

    function new();
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int i = 0; i <= DEPTH; i++) begin
            x = (HALF_PI * i) / DEPTH;
            x2 = longint'((64'(x) * 64'(x)) >> 30);
            term = x;
            sum = x;
            for (int t = 1; t < 10; t++) begin
                term = longint'((64'(term) * 64'(x2)) >> 30);
                term = term / ((2 * t) * (2 * t + 1));
                if (t % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            if (sum < 0) sum = 0;
            sine_tab[i] = (sum + 32768) >>> 16;
        end
        errors = 0;
        reset_pose();
    endfunction

    function void reset_pose();
        inv_wheelbase = 102;
        min_steer = -2145;
        max_steer = 2145;
        x_pos = 0;
        y_pos = 0;
        steer = 0;
        head = 0;
        elapsed = 0;
    endfunction

    function void write_reg(int idx, logic [15:0] val);
        if (idx == vks_pkg::REG_INV_WHEELBASE) inv_wheelbase = val;
        else if (idx == vks_pkg::REG_MIN_STEER) min_steer = longint'($signed(val[13:0]));
        else if (idx == vks_pkg::REG_MAX_STEER) max_steer = longint'(val[12:0]);
    endfunction

    function longint sine_at(longint n);
        longint q;
        longint idx;
        n = n % (4 * DEPTH);
        q = n / DEPTH;
        idx = n % DEPTH;
        case (q)
            0: return sine_tab[idx];
            1: return sine_tab[DEPTH - idx];
            2: return -sine_tab[idx];
            default: return -sine_tab[DEPTH - idx];
        endcase
    endfunction

    function longint phase_of(longint a);
        longint p;
        p = a + 2 * TWO_PI;
        p = (p * (4 * DEPTH) + TWO_PI / 2) / TWO_PI;
        return p % (4 * DEPTH);
    endfunction

    function longint round_sh(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function void note_input(logic [47:0] beat);
        longint dt;
        longint vel;
        longint rate;
        longint sp;
        longint hp;
        longint s_sin;
        longint s_cos;
        longint h_sin;
        longint h_cos;
        longint dv;
        longint dh;
        longint nh;
        longint ns;
        pose_t p;
        dt = longint'(beat[15:0]);
        vel = longint'($signed(beat[31:16]));
        rate = longint'($signed(beat[47:32]));
        sp = phase_of(steer);
        hp = phase_of(head);
        s_sin = sine_at(sp);
        s_cos = sine_at(sp + DEPTH);
        h_sin = sine_at(hp);
        h_cos = sine_at(hp + DEPTH);
        dv = dt * vel;
        dh = round_sh(dv * longint'(inv_wheelbase) * s_sin, 34);
        if (dh > TWO_PI) dh = TWO_PI;
        if (dh < -TWO_PI) dh = -TWO_PI;
        nh = head + dh;
        if (nh < 0) nh += TWO_PI;
        if (nh > TWO_PI) nh -= TWO_PI;
        ns = steer + round_sh(dt * rate, 16);
        if (ns < min_steer) ns = min_steer;
        if (ns > max_steer) ns = max_steer;
        x_pos = sat32(x_pos + round_sh(dv * s_cos * h_cos, 36));
        y_pos = sat32(y_pos + round_sh(dv * s_cos * h_sin, 36));
        steer = ns;
        head = nh;
        elapsed = elapsed + 32'(dt);
        p.pos_x = 32'(x_pos);
        p.pos_y = 32'(y_pos);
        p.steer_angle = 14'(steer);
        p.heading = 15'(head);
        p.elapsed = elapsed;
        pending.push_back(p);
    endfunction

    function void check_result(logic [127:0] beat);
        pose_t want;
        pose_t got;
        got.pos_x = beat[31:0];
        got.pos_y = beat[63:32];
        got.steer_angle = beat[77:64];
        got.heading = beat[92:78];
        got.elapsed = beat[124:93];
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, beat);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.pos_x !== want.pos_x) begin
            $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
            errors++;
        end
        if (got.pos_y !== want.pos_y) begin
            $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
            errors++;
        end
        if (got.steer_angle !== want.steer_angle) begin
            $display("%0t: steer_angle expected %h actual %h", $time,
                     want.steer_angle, got.steer_angle);
            errors++;
        end
        if (got.heading !== want.heading) begin
            $display("%0t: heading expected %h actual %h", $time, want.heading, got.heading);
            errors++;
        end
        if (got.elapsed !== want.elapsed) begin
            $display("%0t: elapsed expected %h actual %h", $time, want.elapsed, got.elapsed);
            errors++;
        end
        if (beat[127:125] !== 3'b000) begin
            $display("%0t: fill bits expected 0 actual %b", $time, beat[127:125]);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam longint CYCLE_LIMIT = 2000000;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [47:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [127:0] m_tdata;

    pose_scoreboard pose_sb;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles;

    vehicle_kinematic_step uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        pose_sb = new();
        recv_stall_pct = 0;
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver stalls at random; results are checked at the accepting edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) pose_sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(int idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= 2'(idx);
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        pose_sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // tvalid stays high after acceptance until the next call drives new data
    // or idles; drain() drops it at the end of a run.
    task automatic send_step(logic [15:0] dt, logic [15:0] vel, logic [15:0] rate);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {rate, vel, dt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pose_sb.note_input({rate, vel, dt});
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pose_sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_steps(int n);
        logic [15:0] dt;
        logic [15:0] vel;
        logic [15:0] rate;
        for (int i = 0; i < n; i++) begin
            dt = 16'($urandom);
            vel = 16'($urandom);
            rate = 16'($urandom);
            // Half the steps get a small dt or rate, to keep off the limits.
            case ($urandom_range(3))
                0: dt = 16'($urandom_range(2000));
                1: rate = 16'($signed(16'($urandom_range(4000))) - 16'sd2000);
                default: ;
            endcase
            send_step(dt, vel, rate);
        end
    endtask

    initial begin
        aresetn = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        send_idle_pct = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: field extremes, heading wrap both ways, steering clamps.
        send_step(16'hFFFF, 16'h7FFF, 16'h7FFF);
        send_step(16'hFFFF, 16'h7FFF, 16'h7FFF);
        send_step(16'hFFFF, 16'h8000, 16'h8000);
        send_step(16'hFFFF, 16'h8000, 16'h8000);
        send_step(16'h0000, 16'h7FFF, 16'h7FFF);
        send_step(16'h1000, 16'h0000, 16'h0000);
        send_step(16'hFFFF, 16'h7FFF, 16'h0000);
        send_step(16'hFFFF, 16'h8000, 16'h0000);
        drain();
        write_reg(vks_pkg::REG_INV_WHEELBASE, 16'hFFFF);
        write_reg(vks_pkg::REG_MIN_STEER, 16'(-6434));
        write_reg(vks_pkg::REG_MAX_STEER, 16'd6434);
        send_step(16'hFFFF, 16'h7FFF, 16'h7FFF);
        send_step(16'hFFFF, 16'h7FFF, 16'h7FFF);
        send_step(16'hFFFF, 16'h8000, 16'h8000);
        send_step(16'hFFFF, 16'h7FFF, 16'h1234);
        drain();
        // Equal limits, then a zero inverse wheelbase.
        write_reg(vks_pkg::REG_MIN_STEER, 16'd0);
        write_reg(vks_pkg::REG_MAX_STEER, 16'd0);
        send_step(16'h8000, 16'h4000, 16'h7FFF);
        drain();
        write_reg(vks_pkg::REG_MIN_STEER, 16'(-100));
        write_reg(vks_pkg::REG_MAX_STEER, 16'd0);
        write_reg(vks_pkg::REG_INV_WHEELBASE, 16'd0);
        send_step(16'hFFFF, 16'h7FFF, 16'h8000);
        send_step(16'hFFFF, 16'h7FFF, 16'h8000);
        drain();
        write_reg(3, 16'hFFFF);
        write_reg(vks_pkg::REG_INV_WHEELBASE, 16'd1);
        write_reg(vks_pkg::REG_MIN_STEER, 16'h3FFF);
        write_reg(vks_pkg::REG_MAX_STEER, 16'h1FFF);
        send_step(16'hFFFF, 16'h7FFF, 16'h7FFF);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 49; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 49; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            write_reg(vks_pkg::REG_INV_WHEELBASE, (phase == 4) ? 16'hFFFF :
                      16'($urandom_range(1, 400)));
            write_reg(vks_pkg::REG_MIN_STEER, 16'(-$urandom_range(6434)));
            write_reg(vks_pkg::REG_MAX_STEER, 16'($urandom_range(6434)));
            random_steps(85);
            drain();
        end

        if (pose_sb.errors == 0 && pose_sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- vehicle_kinematic_step.f -----
src/vks_pkg.sv
src/vks_mul.sv
src/vehicle_kinematic_step.sv
bench/testbench.sv
